@@ src/ready_queue_dispatch_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// Ready queue dispatch scheduler assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef READY_QUEUE_DISPATCH_SCHEDULER_DEFINES_SVH
`define READY_QUEUE_DISPATCH_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define RQDS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqds assertion failed");
`define RQDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rqds assertion failed");
`else
`define RQDS_ASSERT_SAME(label, ante, cons)
`define RQDS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/rqds_pkg.sv @@
// ----------------------------------------------------------------------------
// Ready queue dispatch scheduler package
// Shared constants, codes, entry layout and control structures.
// ----------------------------------------------------------------------------
package rqds_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] SELECT_LIMIT  = 16'd100;
    localparam logic [7:0]  QUANTUM_RESET = 8'd5;
    localparam logic [4:0]  CORES_RESET   = 5'd1;

    localparam logic       KIND_ENQUEUE  = 1'b0;
    localparam logic       KIND_DISPATCH = 1'b1;

    localparam logic [1:0] REG_POLICY  = 2'd0;
    localparam logic [1:0] REG_QUANTUM = 2'd1;
    localparam logic [1:0] REG_CORES   = 2'd2;

    typedef enum logic [1:0] {
        POL_ROUND_ROBIN = 2'd0,
        POL_SHORTEST    = 2'd1,
        POL_PRIORITY    = 2'd2,
        POL_RESERVED    = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_PICK,
        ST_MOVE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] burst;
        logic [6:0]  prio;
        logic [15:0] wait_cnt;
    } entry_t;

    typedef struct packed {
        logic             clear;
        logic             load;
        logic [IDX_W-1:0] index;
        policy_t          policy;
        logic             thr_ok;
        logic [15:0]      threshold;
    } scan_ctl_t;

endpackage

@@ src/rqds_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rqds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/rqds_select.sv @@
// ----------------------------------------------------------------------------
// Ready queue selection unit
// Compares one entry per cycle against the running best and ages the entry.
// ----------------------------------------------------------------------------
module rqds_select (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rqds_pkg::scan_ctl_t              ctl,
    input  rqds_pkg::entry_t                 entry,
    output rqds_pkg::entry_t                 aged,
    output logic [rqds_pkg::IDX_W-1:0]       sel_idx,
    output logic [7:0]                       sel_id,
    output logic [15:0]                      sel_burst
);
    import rqds_pkg::*;

    logic [15:0]      best_reg, best_next;
    logic [IDX_W-1:0] sel_idx_reg, sel_idx_next;
    logic [7:0]       sel_id_reg, sel_id_next;
    logic [15:0]      sel_burst_reg, sel_burst_next;
    logic             qualifies;
    logic [15:0]      key;
    logic             match;

    always_comb
    begin
        qualifies = 1'b0;
        key       = entry.burst;
        case (ctl.policy)
            POL_SHORTEST:
            begin
                key       = entry.burst;
                qualifies = entry.burst < best_reg;
            end
            POL_PRIORITY:
            begin
                key       = {9'd0, entry.prio};
                qualifies = {9'd0, entry.prio} <= best_reg;
            end
            default:
            begin
                qualifies = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        best_next      = best_reg;
        sel_idx_next   = sel_idx_reg;
        sel_id_next    = sel_id_reg;
        sel_burst_next = sel_burst_reg;
        if (ctl.clear)
        begin
            best_next = SELECT_LIMIT;
        end
        else if (ctl.load)
        begin
            if (ctl.index == '0 || qualifies)
            begin
                sel_idx_next   = ctl.index;
                sel_id_next    = entry.id;
                sel_burst_next = entry.burst;
            end
            if (qualifies)
            begin
                best_next = key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= SELECT_LIMIT;
            sel_idx_reg   <= '0;
            sel_id_reg    <= '0;
            sel_burst_reg <= '0;
        end
        else
        begin
            best_reg      <= best_next;
            sel_idx_reg   <= sel_idx_next;
            sel_id_reg    <= sel_id_next;
            sel_burst_reg <= sel_burst_next;
        end
    end

    assign match = ctl.thr_ok && (entry.wait_cnt == ctl.threshold);

    always_comb
    begin
        aged = entry;
        if (match)
        begin
            if (entry.prio > 7'd1)
            begin
                aged.prio     = entry.prio - 7'd1;
                aged.wait_cnt = 16'd1;
            end
        end
        else
        begin
            aged.wait_cnt = entry.wait_cnt + 16'd1;
        end
    end

    assign sel_idx   = sel_idx_reg;
    assign sel_id    = sel_id_reg;
    assign sel_burst = sel_burst_reg;

endmodule

@@ src/ready_queue_dispatch_scheduler.sv @@
// Enqueue: busy stays low and the next command is taken at once.
// Dispatch: busy while the queued entries are scanned and later entries moved up,
// with the result strobed in the cycle after.
// The single read port of the entry RAM sets the pace: one entry per cycle is scanned,
// then later entries move up one place per cycle. An ignored dispatch leaves busy low.
// Reset (rst_n low, asynchronous) empties the queue and loads the register defaults.
// ----------------------------------------------------------------------------
// Ready queue dispatch scheduler
// Keeps ready processes in arrival order and dispatches one by the set policy.
// ----------------------------------------------------------------------------
`include "ready_queue_dispatch_scheduler_defines.svh"

module ready_queue_dispatch_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [7:0]  proc_id,
    input  logic [15:0] burst_left,
    input  logic [6:0]  base_priority,
    input  logic        cores_busy,
    output logic        done,
    output logic [7:0]  chosen_id,
    output logic [15:0] slice,
    output logic [15:0] remainder,
    output logic        was_split
);
    import rqds_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic             mv_pend_reg, mv_pend_next;
    logic [IDX_W-1:0] mv_dest_reg, mv_dest_next;
    logic [15:0]      thr_reg, thr_next;
    logic             thr_ok_reg, thr_ok_next;
    policy_t          policy_reg;
    logic [7:0]       quantum_reg;
    logic [4:0]       cores_reg;
    logic             done_reg, done_next;
    logic [7:0]       chosen_id_reg;
    logic [15:0]      slice_reg, remainder_reg;
    logic             was_split_reg;

    logic             cfg_write;
    logic             accept;
    logic             do_enqueue;
    logic             do_dispatch;
    logic             scan_last;
    logic             move_more;
    logic [12:0]      thr_prod;
    logic [15:0]      quantum_ext;
    logic             split;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;
    entry_t           new_entry;
    entry_t           aged;
    scan_ctl_t        scan_ctl;
    logic [IDX_W-1:0] sel_idx;
    logic [7:0]       sel_id;
    logic [15:0]      sel_burst;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_ROUND_ROBIN;
            quantum_reg <= QUANTUM_RESET;
            cores_reg   <= CORES_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_POLICY:  policy_reg  <= policy_t'(pwdata[1:0]);
                REG_QUANTUM: quantum_reg <= pwdata[7:0];
                REG_CORES:   cores_reg   <= pwdata[4:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_POLICY:  prdata = {30'd0, policy_reg};
            REG_QUANTUM: prdata = {24'd0, quantum_reg};
            REG_CORES:   prdata = {27'd0, cores_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Command decode.
    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign do_enqueue  = accept && (kind == KIND_ENQUEUE) && (fill_reg < CNT_W'(QUEUE_DEPTH));
    assign do_dispatch = accept && (kind == KIND_DISPATCH) && !cores_busy && (fill_reg != '0);
    assign scan_last   = (CNT_W'(idx_reg) == fill_reg - CNT_W'(1));
    assign move_more   = (CNT_W'(idx_reg) + CNT_W'(1) < fill_reg);
    assign thr_prod    = 13'(quantum_reg - 8'd1) * 13'(cores_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (do_dispatch)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                if (!move_more)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath control.
    always_comb
    begin
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        mv_pend_next = 1'b0;
        mv_dest_next = mv_dest_reg;
        thr_next     = thr_reg;
        thr_ok_next  = thr_ok_reg;
        done_next    = 1'b0;
        ram_raddr    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next    = '0;
                thr_next    = 16'(thr_prod);
                thr_ok_next = (quantum_reg != 8'd0);
                if (do_enqueue)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                ram_raddr = idx_reg;
                pend_next = 1'b1;
                pidx_next = idx_reg;
                if (!scan_last)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_PICK:
            begin
                idx_next = sel_idx;
            end
            ST_MOVE:
            begin
                if (move_more)
                begin
                    ram_raddr    = idx_reg + IDX_W'(1);
                    mv_pend_next = 1'b1;
                    mv_dest_next = idx_reg;
                    idx_next     = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                fill_next = fill_reg - CNT_W'(1);
                done_next = 1'b1;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            pidx_reg    <= '0;
            mv_pend_reg <= 1'b0;
            mv_dest_reg <= '0;
            thr_reg     <= '0;
            thr_ok_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            pidx_reg    <= pidx_next;
            mv_pend_reg <= mv_pend_next;
            mv_dest_reg <= mv_dest_next;
            thr_reg     <= thr_next;
            thr_ok_reg  <= thr_ok_next;
            done_reg    <= done_next;
        end
    end

    // Entry storage.
    assign new_entry = '{id: proc_id, burst: burst_left, prio: base_priority, wait_cnt: 16'd0};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fill_reg[IDX_W-1:0];
        ram_wdata = new_entry;
        if (mv_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = mv_dest_reg;
            ram_wdata = ram_rdata;
        end
        else if (pend_reg)
        begin
            ram_we    = (policy_reg == POL_PRIORITY);
            ram_waddr = pidx_reg;
            ram_wdata = aged;
        end
        else if (do_enqueue)
        begin
            ram_we = 1'b1;
        end
    end

    rqds_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_ctl = '{
        clear:     do_dispatch,
        load:      pend_reg,
        index:     pidx_reg,
        policy:    policy_reg,
        thr_ok:    thr_ok_reg,
        threshold: thr_reg
    };

    rqds_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .entry     (ram_rdata),
        .aged      (aged),
        .sel_idx   (sel_idx),
        .sel_id    (sel_id),
        .sel_burst (sel_burst)
    );

    // Result word.
    assign quantum_ext = {8'd0, quantum_reg};
    assign split       = sel_burst > quantum_ext;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH)
        begin
            chosen_id_reg <= sel_id;
            slice_reg     <= split ? quantum_ext : sel_burst;
            remainder_reg <= split ? (sel_burst - quantum_ext) : 16'd0;
            was_split_reg <= split;
        end
    end

    assign done      = done_reg;
    assign chosen_id = chosen_id_reg;
    assign slice     = slice_reg;
    assign remainder = remainder_reg;
    assign was_split = was_split_reg;

    `RQDS_ASSERT_NEXT(a_done_after_finish, state_reg == ST_FINISH, done_reg)
    `RQDS_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= CNT_W'(QUEUE_DEPTH))
    `RQDS_ASSERT_SAME(a_fill_drops_on_done, done_reg, fill_reg == $past(fill_reg) - CNT_W'(1))
    `RQDS_ASSERT_SAME(a_sel_in_queue, state_reg == ST_MOVE, CNT_W'(sel_idx) < fill_reg)

endmodule
